[rtl/brlt_pkg.sv]
// Package: sizes, codes, entry layout and controller states of the byte-range lock table.
package brlt_pkg;

	localparam int ENTRIES     = 64;
	localparam int OFFSET_BITS = 32;
	localparam int IDX_W       = $clog2(ENTRIES);
	localparam int CNT_W       = $clog2(ENTRIES + 1);

	typedef logic [OFFSET_BITS-1:0] offset_t;

	typedef enum logic [1:0] {
		OP_TEST    = 2'd0,
		OP_LOCK    = 2'd1,
		OP_UNLOCK  = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_BUSY = 2'd1,
		STAT_WAIT = 2'd2,
		STAT_FULL = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PASS1,
		S_PASS2,
		S_COMMIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [15:0] file;
		logic [7:0]  owner;
		offset_t     lo;
		offset_t     hi;
	} entry_t;

endpackage

[rtl/byte_range_lock_table.sv]
// Byte-range lock table: entry pool, scan sequencer and result register.
//
// A pool of brlt_pkg::ENTRIES lock entries, each holding a file, an owner and a half-open
// byte range [lo, hi). Valid bits live in flip-flops and clear at reset; the entry payload
// sits in a memory with a registered read, so one entry is examined per cycle.
// Every transaction runs a first scan over all entries (conflict check, lowest free entry,
// or release of the owner's entries in the file). Lock and unlock, when they go on, run a
// second scan (merge, or trim/split) and then a commit state that writes the reserved
// entry; for unlock it writes only the upper piece left by a split, if any. Test,
// release-all, and lock or unlock that stop after the first scan (conflict or no free
// entry) load the result register after that scan; lock and unlock that go on load it
// after the commit. in_stall is high from accept until the result is loaded into the
// output register; a new transaction may be accepted while that result still waits on
// out_stall. blocking_owner is the owner of the lowest-index conflicting entry, zero when
// there is no conflict. free_entries is the count after the operation.
module byte_range_lock_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [15:0] file_id,
	input  logic [7:0]  owner_id,
	input  logic [31:0] range_begin,
	input  logic [31:0] range_end,
	input  logic        wait_mode,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  blocking_owner,
	output logic [6:0]  free_entries
);

	// control state
	brlt_pkg::state_t              state_q, state_d;
	logic [brlt_pkg::ENTRIES-1:0]  valid_q;
	logic [brlt_pkg::CNT_W-1:0]    free_q;
	logic [brlt_pkg::CNT_W-1:0]    cnt_q;
	logic                          act_s1;
	logic [brlt_pkg::IDX_W-1:0]    idx_s1;
	logic                          conf_q, ffound_q, spare_q, out_valid_q;

	// request and working registers
	brlt_pkg::op_t                 op_q;
	logic [15:0]                   file_q;
	logic [7:0]                    owner_q;
	brlt_pkg::offset_t             req_lo_q, req_hi_q, acc_lo_q, acc_hi_q;
	brlt_pkg::offset_t             spare_lo_q, spare_hi_q;
	logic                          wait_q;
	logic [7:0]                    blk_q;
	logic [brlt_pkg::IDX_W-1:0]    g_q;
	logic [1:0]                    status_q;
	logic [7:0]                    blocking_q;
	logic [6:0]                    free_out_q;

	// entry memory
	brlt_pkg::entry_t              mem_q [brlt_pkg::ENTRIES];
	brlt_pkg::entry_t              rd_s1;

	// sequencer strobes
	logic                          accept, issue, pass_last, out_ld;
	logic                          mem_we, clr_v, set_v;
	logic [brlt_pkg::IDX_W-1:0]    mem_wa;
	brlt_pkg::entry_t              mem_wd;
	logic [1:0]                    status_d;

	// per-entry compares on the entry just read
	logic cur_v, same_file, own, mine, req_ov, merge_hit, conf_hit, free_hit;
	logic in_scan, conf_now, free_now;

	assign accept    = in_valid && (state_q == brlt_pkg::S_IDLE);
	assign in_stall  = (state_q != brlt_pkg::S_IDLE);
	assign in_scan   = (state_q == brlt_pkg::S_PASS1) || (state_q == brlt_pkg::S_PASS2);
	assign issue     = in_scan && (cnt_q < brlt_pkg::CNT_W'(brlt_pkg::ENTRIES));
	assign pass_last = act_s1 && (cnt_q == brlt_pkg::CNT_W'(brlt_pkg::ENTRIES));

	assign cur_v     = valid_q[idx_s1];
	assign same_file = (rd_s1.file == file_q);
	assign own       = (rd_s1.owner == owner_q);
	assign mine      = cur_v && same_file && own;
	assign req_ov    = (req_hi_q > rd_s1.lo) && (req_lo_q < rd_s1.hi);
	assign merge_hit = !((acc_hi_q < rd_s1.lo) || (acc_lo_q > rd_s1.hi));
	assign conf_hit  = act_s1 && ((op_q == brlt_pkg::OP_TEST) || (op_q == brlt_pkg::OP_LOCK))
	                   && cur_v && same_file && !own && req_ov && !conf_q;
	assign free_hit  = act_s1 && !cur_v && !ffound_q;
	assign conf_now  = conf_q || conf_hit;
	assign free_now  = ffound_q || free_hit;

	// next state and strobes
	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		mem_wa  = idx_s1;
		mem_wd  = rd_s1;
		clr_v   = 1'b0;
		set_v   = 1'b0;
		out_ld  = 1'b0;
		case (state_q)
			brlt_pkg::S_IDLE: begin
				if (in_valid)
					state_d = brlt_pkg::S_PASS1;
			end
			brlt_pkg::S_PASS1: begin
				if (act_s1 && (op_q == brlt_pkg::OP_RELEASE) && mine)
					clr_v = 1'b1;
				if (pass_last) begin
					case (op_q)
						brlt_pkg::OP_LOCK:
							state_d = (!conf_now && free_now) ? brlt_pkg::S_PASS2
							                                  : brlt_pkg::S_DONE;
						brlt_pkg::OP_UNLOCK:
							state_d = free_now ? brlt_pkg::S_PASS2 : brlt_pkg::S_DONE;
						default:
							state_d = brlt_pkg::S_DONE;
					endcase
				end
			end
			brlt_pkg::S_PASS2: begin
				if (act_s1 && mine) begin
					if (op_q == brlt_pkg::OP_LOCK) begin
						if (merge_hit)
							clr_v = 1'b1;
					end else if ((idx_s1 != g_q) && req_ov) begin
						if (req_lo_q <= rd_s1.lo) begin
							if (req_hi_q >= rd_s1.hi) begin
								clr_v = 1'b1;
							end else begin
								mem_we    = 1'b1;
								mem_wd.lo = req_hi_q;
							end
						end else begin
							// keep the lower piece; the upper piece may go to the spare
							mem_we    = 1'b1;
							mem_wd.hi = req_lo_q;
						end
					end
				end
				if (pass_last)
					state_d = brlt_pkg::S_COMMIT;
			end
			brlt_pkg::S_COMMIT: begin
				mem_wa       = g_q;
				mem_wd.file  = file_q;
				mem_wd.owner = owner_q;
				if (op_q == brlt_pkg::OP_LOCK) begin
					mem_wd.lo = acc_lo_q;
					mem_wd.hi = acc_hi_q;
					mem_we    = 1'b1;
					set_v     = 1'b1;
				end else begin
					mem_wd.lo = spare_lo_q;
					mem_wd.hi = spare_hi_q;
					mem_we    = spare_q;
					set_v     = spare_q;
				end
				state_d = brlt_pkg::S_DONE;
			end
			brlt_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_ld  = 1'b1;
					state_d = brlt_pkg::S_IDLE;
				end
			end
			default: state_d = brlt_pkg::S_IDLE;
		endcase
	end

	// final status from the scan flags
	always_comb begin
		if (((op_q == brlt_pkg::OP_TEST) || (op_q == brlt_pkg::OP_LOCK)) && conf_q)
			status_d = wait_q ? brlt_pkg::STAT_WAIT : brlt_pkg::STAT_BUSY;
		else if (((op_q == brlt_pkg::OP_LOCK) || (op_q == brlt_pkg::OP_UNLOCK)) && !ffound_q)
			status_d = brlt_pkg::STAT_FULL;
		else
			status_d = brlt_pkg::STAT_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= brlt_pkg::S_IDLE;
			valid_q     <= '0;
			free_q      <= brlt_pkg::CNT_W'(brlt_pkg::ENTRIES);
			cnt_q       <= '0;
			act_s1      <= 1'b0;
			conf_q      <= 1'b0;
			ffound_q    <= 1'b0;
			spare_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_v) begin
				valid_q[idx_s1] <= 1'b0;
				free_q          <= free_q + brlt_pkg::CNT_W'(1);
			end
			if (set_v) begin
				valid_q[g_q] <= 1'b1;
				free_q       <= free_q - brlt_pkg::CNT_W'(1);
			end
			if (accept || (state_q == brlt_pkg::S_PASS1 && pass_last)) begin
				cnt_q  <= '0;
				act_s1 <= 1'b0;
			end else if (in_scan) begin
				act_s1 <= issue;
				if (issue)
					cnt_q <= cnt_q + brlt_pkg::CNT_W'(1);
			end else begin
				act_s1 <= 1'b0;
			end
			if (accept) begin
				conf_q   <= 1'b0;
				ffound_q <= 1'b0;
				spare_q  <= 1'b0;
			end else begin
				if (state_q == brlt_pkg::S_PASS1 && conf_hit)
					conf_q <= 1'b1;
				if (state_q == brlt_pkg::S_PASS1 && free_hit)
					ffound_q <= 1'b1;
				if (state_q == brlt_pkg::S_PASS2 && mem_we && op_q == brlt_pkg::OP_UNLOCK &&
				    (req_lo_q > rd_s1.lo) && (req_hi_q < rd_s1.hi))
					spare_q <= 1'b1;
			end
			if (out_ld)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= brlt_pkg::op_t'(opcode);
			file_q   <= file_id;
			owner_q  <= owner_id;
			req_lo_q <= brlt_pkg::offset_t'(range_begin);
			req_hi_q <= brlt_pkg::offset_t'(range_end);
			acc_lo_q <= brlt_pkg::offset_t'(range_begin);
			acc_hi_q <= brlt_pkg::offset_t'(range_end);
			wait_q   <= wait_mode;
		end
		if (issue) begin
			rd_s1  <= mem_q[cnt_q[brlt_pkg::IDX_W-1:0]];
			idx_s1 <= cnt_q[brlt_pkg::IDX_W-1:0];
		end
		if (mem_we)
			mem_q[mem_wa] <= mem_wd;
		if (state_q == brlt_pkg::S_PASS1 && conf_hit)
			blk_q <= rd_s1.owner;
		if (state_q == brlt_pkg::S_PASS1 && free_hit)
			g_q <= idx_s1;
		// lock merge: widen the union
		if (state_q == brlt_pkg::S_PASS2 && op_q == brlt_pkg::OP_LOCK && clr_v) begin
			if (acc_lo_q > rd_s1.lo)
				acc_lo_q <= rd_s1.lo;
			if (acc_hi_q < rd_s1.hi)
				acc_hi_q <= rd_s1.hi;
		end
		// unlock split: only the first one keeps its upper piece
		if (state_q == brlt_pkg::S_PASS2 && mem_we && op_q == brlt_pkg::OP_UNLOCK &&
		    (req_lo_q > rd_s1.lo) && (req_hi_q < rd_s1.hi) && !spare_q) begin
			spare_lo_q <= req_hi_q;
			spare_hi_q <= rd_s1.hi;
		end
		if (out_ld) begin
			status_q   <= status_d;
			blocking_q <= (status_d == brlt_pkg::STAT_BUSY || status_d == brlt_pkg::STAT_WAIT)
			              ? blk_q : 8'd0;
			free_out_q <= 7'(free_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign blocking_owner = blocking_q;
	assign free_entries   = free_out_q;

endmodule
